// File: src/rth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the RGB to HSL converter
// Channel widths, divider depth and the hue sector code.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int CH_W              = 8;   // colour channel width
  localparam int HUE_W             = 9;   // hue, 0..359
  localparam int SUM_W             = 9;   // max + min, 0..510
  localparam int HUE_NUM_W         = 17;  // hue numerator, below 360 * 255
  localparam int SAT_FRAC_BITS_DEF = 16;
  localparam int DIV_STAGES        = 5;   // register stages in each divider

  // which channel is the maximum, and for red which side of zero the hue lies
  typedef enum logic [1:0] {
    HSEL_RED_POS,
    HSEL_RED_NEG,
    HSEL_GREEN,
    HSEL_BLUE
  } hsel_t;

endpackage

// File: src/rgb_to_hsl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl: 8-bit RGB pixel to hue, saturation and lightness
// Pipelined converter with exact integer hue and saturation division.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel per transfer (red, green, blue in tdata).
//   m_* carries one result per pixel, in order: hue in whole degrees
//   (floor, 0..359), saturation in unsigned fixed point with SAT_FRAC_BITS
//   fraction bits (floor, 1.0 at full saturation) and max + min (0..510).
//   Grey pixels give hue 0 and saturation 0.
//   The pipeline holds two stages of max/min and numerator set-up, the
//   divider stages, and the output register. Throughput is one pixel per
//   clock while m_tready allows it; the hue and saturation dividers each
//   retire ceil(quotient bits / DIV_STAGES) bits per stage.
//   The whole pipeline advances together; when m_tready is low with a
//   result held, s_tready drops and every stage holds its contents.
//   Reset clears all valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
module rgb_to_hsl #(
  parameter int SAT_FRAC_BITS = rth_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [3*rth_pkg::CH_W-1:0] s_tdata,  // red, green, blue
  output logic m_tvalid,
  input  logic m_tready,
  // hue, saturation, lightness_sum, zero fill
  output logic [((rth_pkg::HUE_W + SAT_FRAC_BITS + 1 + rth_pkg::SUM_W + 7) / 8) * 8 - 1:0]
               m_tdata
);

  localparam int CH_W    = rth_pkg::CH_W;
  localparam int HUE_W   = rth_pkg::HUE_W;
  localparam int SUM_W   = rth_pkg::SUM_W;
  localparam int HNUM_W  = rth_pkg::HUE_NUM_W;
  localparam int SAT_W   = SAT_FRAC_BITS + 1;
  localparam int SNUM_W  = CH_W + SAT_FRAC_BITS;
  localparam int STAGES  = rth_pkg::DIV_STAGES;
  localparam int FIELD_W = HUE_W + SAT_W + SUM_W;
  localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage 1: max, min, sector, difference ----------------
  logic [CH_W-1:0]  red, green, blue;
  logic [CH_W-1:0]  mx_c, mn_c;
  logic signed [CH_W:0] diff_c;
  rth_pkg::hsel_t   hsel_c;

  assign red   = s_tdata[CH_W-1:0];
  assign green = s_tdata[2*CH_W-1:CH_W];
  assign blue  = s_tdata[3*CH_W-1:2*CH_W];

  always_comb begin
    mx_c = red;
    mn_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c)  mx_c = blue;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c)  mn_c = blue;
    // red wins ties, then green
    priority if (mx_c == red) begin
      diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
      hsel_c = (green >= blue) ? rth_pkg::HSEL_RED_POS : rth_pkg::HSEL_RED_NEG;
    end else if (mx_c == green) begin
      diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
      hsel_c = rth_pkg::HSEL_GREEN;
    end else begin
      diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
      hsel_c = rth_pkg::HSEL_BLUE;
    end
  end

  logic                 v1;
  logic [CH_W-1:0]      s1_d;
  logic [SUM_W-1:0]     s1_sum;
  logic signed [CH_W:0] s1_diff;
  rth_pkg::hsel_t       s1_hsel;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d    <= mx_c - mn_c;
      s1_sum  <= SUM_W'(mx_c) + SUM_W'(mn_c);
      s1_diff <= diff_c;
      s1_hsel <= hsel_c;
    end
  end

  // ---------------- stage 2: numerators and saturation divisor ----------------
  logic [HNUM_W-1:0]        base_c;
  logic signed [HNUM_W+1:0] hnum_wide;
  logic [CH_W-1:0]          sden_c;

  always_comb begin
    unique case (s1_hsel)
      rth_pkg::HSEL_RED_POS: base_c = '0;
      rth_pkg::HSEL_RED_NEG: base_c = HNUM_W'(s1_d) * HNUM_W'(360);
      rth_pkg::HSEL_GREEN:   base_c = HNUM_W'(s1_d) * HNUM_W'(120);
      rth_pkg::HSEL_BLUE:    base_c = HNUM_W'(s1_d) * HNUM_W'(240);
      default:               base_c = '0;
    endcase
    hnum_wide = $signed({2'b00, base_c}) + (HNUM_W+2)'(s1_diff) * $signed((HNUM_W+2)'(60));
    // dark half divides by the sum, light half by 510 - sum
    sden_c = (s1_sum <= SUM_W'(255)) ? s1_sum[CH_W-1:0]
                                     : CH_W'(SUM_W'(510) - s1_sum);
  end

  logic              v2;
  logic              s2_grey;
  logic [SUM_W-1:0]  s2_sum;
  logic [HNUM_W-1:0] s2_hnum;
  logic [CH_W-1:0]   s2_hden;
  logic [SNUM_W-1:0] s2_snum;
  logic [CH_W-1:0]   s2_sden;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_grey <= (s1_d == '0);
      s2_sum  <= s1_sum;
      s2_hnum <= hnum_wide[HNUM_W-1:0];
      s2_hden <= s1_d;
      s2_snum <= {s1_d, {SAT_FRAC_BITS{1'b0}}};
      s2_sden <= sden_c;
    end
  end

  // ---------------- divider stages ----------------
  logic [HUE_W-1:0] hue_q;
  logic [SAT_W-1:0] sat_q;

  rth_div #(
    .NUM_W  (HNUM_W),
    .DEN_W  (CH_W),
    .Q_W    (HUE_W),
    .STAGES (STAGES)
  ) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (s2_hnum),
    .den (s2_hden),
    .quo (hue_q)
  );

  rth_div #(
    .NUM_W  (SNUM_W),
    .DEN_W  (CH_W),
    .Q_W    (SAT_W),
    .STAGES (STAGES)
  ) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (s2_snum),
    .den (s2_sden),
    .quo (sat_q)
  );

  // side data travelling alongside the dividers
  logic             vd     [STAGES];
  logic             grey_d [STAGES];
  logic [SUM_W-1:0] sum_d  [STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v2;
      for (int i = 1; i < STAGES; i++) vd[i] <= vd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grey_d[0] <= s2_grey;
      sum_d[0]  <= s2_sum;
      for (int i = 1; i < STAGES; i++) begin
        grey_d[i] <= grey_d[i-1];
        sum_d[i]  <= sum_d[i-1];
      end
    end
  end

  // ---------------- output register ----------------
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [SUM_W-1:0] lightness_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue           <= grey_d[STAGES-1] ? '0 : hue_q;
      saturation    <= grey_d[STAGES-1] ? '0 : sat_q;
      lightness_sum <= sum_d[STAGES-1];
    end
  end

  assign m_tdata = {{(OUT_W - FIELD_W){1'b0}}, lightness_sum, saturation, hue};

  // ---------------- assertions ----------------
  a_hue_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hue < HUE_W'(360)))
    else $error("hue out of range");

  a_sat_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (saturation <= (SAT_W'(1) << SAT_FRAC_BITS)))
    else $error("saturation above one");

  a_hue_needs_sat : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (hue != '0)) |-> (saturation != '0))
    else $error("coloured hue with zero saturation");

  a_stall_only_blocked : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (vd[STAGES-1] == $past(vd[STAGES-1])))
    else $error("pipeline moved during stall");

endmodule

// File: src/rth_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_div: pipelined restoring divider
// Unsigned num / den over STAGES register stages, ceil(Q_W / STAGES) quotient
// bits per stage. The caller guarantees num < den << Q_W. Advances on en only.
// ----------------------------------------------------------------------------
module rth_div #(
  parameter int NUM_W  = 17,
  parameter int DEN_W  = rth_pkg::CH_W,
  parameter int Q_W    = 9,
  parameter int STAGES = rth_pkg::DIV_STAGES
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int BPS   = (Q_W + STAGES - 1) / STAGES;
  localparam int PAD_Q = BPS * STAGES;
  localparam int RW    = DEN_W + PAD_Q;

  // index 0 is the unregistered input side
  logic [RW-1:0]    rem   [STAGES];
  logic [DEN_W-1:0] den_p [STAGES];
  logic [PAD_Q-1:0] quo_p [STAGES+1];

  assign rem[0]   = RW'(num);
  assign den_p[0] = den;
  assign quo_p[0] = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [RW-1:0]    rem_c;
    logic [PAD_Q-1:0] quo_c;

    always_comb begin
      rem_c = rem[s];
      quo_c = quo_p[s];
      for (int j = 0; j < BPS; j++) begin
        if (rem_c >= (RW'(den_p[s]) << (PAD_Q - 1 - s * BPS - j))) begin
          rem_c = rem_c - (RW'(den_p[s]) << (PAD_Q - 1 - s * BPS - j));
          quo_c[PAD_Q - 1 - s * BPS - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_p[s+1] <= quo_c;
      end
    end

    // the last stage keeps only its quotient
    if (s < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1]   <= rem_c;
          den_p[s+1] <= den_p[s];
        end
      end
    end
  end

  assign quo = quo_p[STAGES][Q_W-1:0];

endmodule

// File: tb/rgb_to_hsl_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_tb: self-checking bench for the RGB to HSL converter
// Streams directed and random pixels with random gaps on both sides. Every
// result is checked against an in-bench integer model of the conversion.
// ----------------------------------------------------------------------------
module rgb_to_hsl_tb;

  localparam int CH_W           = rth_pkg::CH_W;
  localparam int HUE_W          = rth_pkg::HUE_W;
  localparam int SUM_W          = rth_pkg::SUM_W;
  localparam int SAT_FRAC       = rth_pkg::SAT_FRAC_BITS_DEF;
  localparam int SAT_W          = SAT_FRAC + 1;
  localparam int IN_W           = 3 * CH_W;
  localparam int OUT_W          = ((HUE_W + SAT_W + SUM_W + 7) / 8) * 8;
  localparam int LATENCY        = rth_pkg::DIV_STAGES + 3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PIXELS  = 450;

  typedef struct packed {
    logic [SUM_W-1:0] lsum;
    logic [SAT_W-1:0] sat;
    logic [HUE_W-1:0] hue;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t        pending_hsl[$];
    int unsigned n_errors;
    int unsigned n_pixels;
    int unsigned n_results;
    int unsigned n_grey;
    int unsigned sector_hits[4];

    // exact integer HSL of one pixel; sector is the hue sector code that set the hue
    function hsl_t convert(input logic [CH_W-1:0] r, g, b,
                           output rth_pkg::hsel_t sector);
      int   ri, gi, bi, mx, mn, d, lsum, num, den;
      hsl_t res;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      mx = ri;
      mn = ri;
      if (gi > mx) mx = gi;
      if (bi > mx) mx = bi;
      if (gi < mn) mn = gi;
      if (bi < mn) mn = bi;
      d    = mx - mn;
      lsum = mx + mn;
      // red wins a tie for the maximum, then green
      if (mx == ri) sector = (gi >= bi) ? rth_pkg::HSEL_RED_POS : rth_pkg::HSEL_RED_NEG;
      else if (mx == gi) sector = rth_pkg::HSEL_GREEN;
      else sector = rth_pkg::HSEL_BLUE;
      res.lsum = lsum[SUM_W-1:0];
      if (d == 0) begin
        res.hue = '0;
        res.sat = '0;
      end else begin
        case (sector)
          rth_pkg::HSEL_RED_POS: num = 60 * (gi - bi);
          rth_pkg::HSEL_RED_NEG: num = 360 * d - 60 * (bi - gi);
          rth_pkg::HSEL_GREEN:   num = 120 * d + 60 * (bi - ri);
          default:               num = 240 * d + 60 * (ri - gi);
        endcase
        num     = num / d;
        res.hue = num[HUE_W-1:0];
        den     = (lsum <= 255) ? lsum : 510 - lsum;
        num     = (d << SAT_FRAC) / den;
        res.sat = num[SAT_W-1:0];
      end
      return res;
    endfunction

    function void note_pixel(input logic [CH_W-1:0] r, g, b);
      rth_pkg::hsel_t sector;
      hsl_t           res;
      res = convert(r, g, b, sector);
      pending_hsl.push_back(res);
      n_pixels++;
      if (r == g && g == b) n_grey++;
      else sector_hits[sector]++;
    endfunction

    function void check_result(input logic [OUT_W-1:0] word);
      hsl_t want;
      hsl_t got;
      got = word[HUE_W+SAT_W+SUM_W-1:0];
      n_results++;
      if (pending_hsl.size() == 0) begin
        $error("result with no pixel outstanding: hue %0d sat %0d lsum %0d",
               got.hue, got.sat, got.lsum);
        n_errors++;
        return;
      end
      want = pending_hsl.pop_front();
      if (got.hue !== want.hue) begin
        $error("hue: expected %0d, got %0d", want.hue, got.hue);
        n_errors++;
      end
      if (got.sat !== want.sat) begin
        $error("saturation: expected %0d, got %0d", want.sat, got.sat);
        n_errors++;
      end
      if (got.lsum !== want.lsum) begin
        $error("lightness_sum: expected %0d, got %0d", want.lsum, got.lsum);
        n_errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;    // red, green, blue
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;          // hue, saturation, lightness_sum, zero fill

  hsl_scoreboard board;
  bit            no_gaps = 1'b0;
  int unsigned   idle_cycles = 0;

  rgb_to_hsl #(
    .SAT_FRAC_BITS(SAT_FRAC)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // starts and ends on a rising edge; ready is sampled at the falling edge
  task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    board.note_pixel(r, g, b);
    @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (board.pending_hsl.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CH_W-1:0] r, g, b;
    int              kind;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // corners, primaries and secondaries, ties and the lightness boundary
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd1,   8'd0);
    send_pixel(8'd255, 8'd0,   8'd1);    // hue just under 360
    send_pixel(8'd200, 8'd100, 8'd150);
    send_pixel(8'd100, 8'd200, 8'd50);
    send_pixel(8'd50,  8'd200, 8'd100);
    send_pixel(8'd100, 8'd50,  8'd200);
    send_pixel(8'd50,  8'd100, 8'd200);
    send_pixel(8'd200, 8'd200, 8'd100);
    send_pixel(8'd200, 8'd100, 8'd200);
    send_pixel(8'd100, 8'd200, 8'd200);
    send_pixel(8'd1,   8'd0,   8'd0);    // full saturation, darkest
    send_pixel(8'd255, 8'd254, 8'd254);  // full saturation, lightest
    send_pixel(8'd128, 8'd127, 8'd127);
    send_pixel(8'd129, 8'd127, 8'd127);
    send_pixel(8'd255, 8'd0,   8'd128);
    send_pixel(8'd127, 8'd127, 8'd128);
    drain_results();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_PIXELS / 2) drain_results();
      r    = 8'($urandom);
      g    = 8'($urandom);
      b    = 8'($urandom);
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          g = r;
          b = r;
        end
        1: g = r;
        2: b = g;
        3: begin
          r = ($urandom_range(0, 1) ? 8'hff : 8'h00) ^ 8'($urandom_range(0, 1));
          g = ($urandom_range(0, 1) ? 8'hff : 8'h00) ^ 8'($urandom_range(0, 1));
          b = ($urandom_range(0, 1) ? 8'hff : 8'h00) ^ 8'($urandom_range(0, 1));
        end
        4: begin
          g = r ^ 8'($urandom_range(0, 3));
          b = r ^ 8'($urandom_range(0, 3));
        end
        5: begin
          // max + min close to 255, either side of the saturation switch
          g = 8'd255 - r + 8'($urandom_range(0, 2));
          b = (r < g) ? 8'($urandom_range(r, g)) : 8'($urandom_range(g, r));
        end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    no_gaps = 1'b0;
    drain_results();
    repeat (LATENCY) @(posedge clk);

    $display("summary: %0d pixels sent, %0d results checked, %0d grey",
             board.n_pixels, board.n_results, board.n_grey);
    $display("summary: hue sectors red rising %0d, red falling %0d, green %0d, blue %0d",
             board.sector_hits[rth_pkg::HSEL_RED_POS],
             board.sector_hits[rth_pkg::HSEL_RED_NEG],
             board.sector_hits[rth_pkg::HSEL_GREEN],
             board.sector_hits[rth_pkg::HSEL_BLUE]);
    if (board.n_errors == 0) begin
      $display("rgb_to_hsl_tb: PASS");
    end else begin
      $display("rgb_to_hsl_tb: FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int               gap;
    logic [OUT_W-1:0] word;
    while (rst) @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
      while (!m_tvalid) @(negedge clk);
      word = m_tdata;
      @(posedge clk);
      board.check_result(word);
    end
  end

  // any transfer on either side resets the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, board.pending_hsl.size());
        $display("rgb_to_hsl_tb: FAIL");
        $finish;
      end
    end
  end

endmodule
